/* rtl/pmst_pkg.sv */
// ----------------------------------------------------------------------------
// pmst_pkg
// Fixed field widths and register constants for the Prim spanning tree core.
// ----------------------------------------------------------------------------
package pmst_pkg;

    localparam int CFG_W         = 5;   // vertex_count register width
    localparam int VTX_FIELD_W   = 4;   // edge_from / edge_to field width
    localparam logic [CFG_W-1:0] CFG_VC_RESET = 5'd16;
    localparam int VC_MIN        = 2;

endpackage

/* rtl/pmst_weight_ram.sv */
// ----------------------------------------------------------------------------
// pmst_weight_ram
// Simple dual-port weight store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pmst_weight_ram #(
    parameter  int DEPTH = 256,
    parameter  int WIDTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/prim_minimum_spanning_tree_core.sv */
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core
// Loads an n x n adjacency matrix and emits the Prim spanning tree edges.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one matrix weight per word, row-major, tlast on the final
//   entry. Words are taken at one per cycle while the block is loading.
//   The word carrying tlast starts the tree search from vertex 0; the slave
//   side is then held off until the last edge has been placed in the output
//   register.
//   Master stream: n-1 edge words in the order chosen; tlast marks the final
//   edge, tuser flags an unreachable remainder (edge 0-0, cost 0).
//   Search: each edge scans all n*n weights at one read per cycle from the
//   store, then drains the read pipe and emits the edge; the emit waits on
//   any output stall.
//   A stalled master side holds the result in the output register and the
//   search waits there; the next load may begin while the final edge waits.
//   Config: vertex_count written via i_cfg_we / i_cfg_wdata while idle;
//   values are clamped to 2..MAX_VERTICES when the search starts.
//   Reset: synchronous active low; vertex_count returns to 16, load address
//   to 0. The weight store is not cleared.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_core #(
    parameter  int MAX_VERTICES = 16,
    parameter  int WEIGHT_BITS  = 16,
    localparam int IN_TW        = ((WEIGHT_BITS + 7) / 8) * 8,
    localparam int OUT_TW       = ((2 * pmst_pkg::VTX_FIELD_W + WEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pmst_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TW-1:0]           s_axis_tdata,  // edge_weight
    input  logic                       s_axis_tlast,  // last_entry
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TW-1:0]          m_axis_tdata,  // edge_from, edge_to, edge_cost
    output logic                       m_axis_tuser,  // unreachable
    output logic                       m_axis_tlast   // last_edge
);

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int CW    = (NW > pmst_pkg::CFG_W) ? NW : pmst_pkg::CFG_W;
    localparam int FW    = pmst_pkg::VTX_FIELD_W;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [pmst_pkg::CFG_W-1:0] r_vc;
    logic [AW-1:0]              r_load_pos, n_load_pos;
    logic [VW-1:0]              r_last_idx, n_last_idx;
    logic [VW-1:0]              r_last_e, n_last_e;
    logic [VW-1:0]              r_edge, n_edge;
    logic [VW-1:0]              r_i, n_i;
    logic [VW-1:0]              r_j, n_j;
    logic [AW-1:0]              r_addr, n_addr;
    logic                       r_p_valid;
    logic [VW-1:0]              r_p_i, r_p_j;
    logic [MAX_VERTICES-1:0]    r_in_tree, n_in_tree;
    logic                       r_found, n_found;
    logic [WEIGHT_BITS-1:0]     r_best, n_best;
    logic [VW-1:0]              r_bx, n_bx;
    logic [VW-1:0]              r_by, n_by;

    logic                       r_out_valid, n_out_valid;
    logic [FW-1:0]              r_out_from, n_out_from;
    logic [FW-1:0]              r_out_to, n_out_to;
    logic [WEIGHT_BITS-1:0]     r_out_cost, n_out_cost;
    logic                       r_out_unr, n_out_unr;
    logic                       r_out_last, n_out_last;

    logic                       in_acc;
    logic                       out_free;
    logic                       emit;
    logic                       issue;
    logic                       cand;
    logic [WEIGHT_BITS-1:0]     rd_data;
    logic [CW-1:0]              vc_ext;
    logic [NW-1:0]              n_eff;

    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign emit          = (r_state == ST_EMIT) && out_free;
    assign issue         = (r_state == ST_SCAN);

    pmst_weight_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WEIGHT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load_pos),
        .i_wdata (s_axis_tdata[WEIGHT_BITS-1:0]),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // clamp vertex count
    always_comb begin
        vc_ext = CW'(r_vc);
        priority if (vc_ext < CW'(pmst_pkg::VC_MIN)) begin
            n_eff = NW'(pmst_pkg::VC_MIN);
        end else if (vc_ext > CW'(MAX_VERTICES)) begin
            n_eff = NW'(MAX_VERTICES);
        end else begin
            n_eff = NW'(vc_ext);
        end
    end

    assign cand = r_p_valid && r_in_tree[r_p_i] && !r_in_tree[r_p_j]
                  && (rd_data != '0) && (!r_found || (rd_data < r_best));

    always_comb begin
        n_state     = r_state;
        n_load_pos  = r_load_pos;
        n_last_idx  = r_last_idx;
        n_last_e    = r_last_e;
        n_edge      = r_edge;
        n_i         = r_i;
        n_j         = r_j;
        n_addr      = r_addr;
        n_in_tree   = r_in_tree;
        n_found     = r_found;
        n_best      = r_best;
        n_bx        = r_bx;
        n_by        = r_by;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_from  = r_out_from;
        n_out_to    = r_out_to;
        n_out_cost  = r_out_cost;
        n_out_unr   = r_out_unr;
        n_out_last  = r_out_last;

        if (cand) begin
            n_found = 1'b1;
            n_best  = rd_data;
            n_bx    = r_p_i;
            n_by    = r_p_j;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_load_pos == AW'(DEPTH - 1)) begin
                        n_load_pos = '0;
                    end else begin
                        n_load_pos = r_load_pos + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_load_pos = '0;
                        n_last_idx = VW'(n_eff - 1'b1);
                        n_last_e   = VW'(n_eff - 2'd2);
                        n_edge     = '0;
                        n_in_tree  = MAX_VERTICES'(1);
                        n_i        = '0;
                        n_j        = '0;
                        n_addr     = '0;
                        n_found    = 1'b0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (r_j == r_last_idx) begin
                    n_j = '0;
                    if (r_i == r_last_idx) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = (r_edge == r_last_e);
                    if (r_found) begin
                        n_out_from       = FW'(r_bx);
                        n_out_to         = FW'(r_by);
                        n_out_cost       = r_best;
                        n_out_unr        = 1'b0;
                        n_in_tree[r_by]  = 1'b1;
                    end else begin
                        n_out_from = '0;
                        n_out_to   = '0;
                        n_out_cost = '0;
                        n_out_unr  = 1'b1;
                    end
                    n_edge  = r_edge + 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_state = (r_edge == r_last_e) ? ST_LOAD : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_vc        <= pmst_pkg::CFG_VC_RESET;
            r_load_pos  <= '0;
            r_edge      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_addr      <= '0;
            r_p_valid   <= 1'b0;
            r_in_tree   <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
            r_load_pos  <= n_load_pos;
            r_edge      <= n_edge;
            r_i         <= n_i;
            r_j         <= n_j;
            r_addr      <= n_addr;
            r_p_valid   <= issue;
            r_in_tree   <= n_in_tree;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
        r_last_e   <= n_last_e;
        r_p_i      <= r_i;
        r_p_j      <= r_j;
        r_best     <= n_best;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_out_from <= n_out_from;
        r_out_to   <= n_out_to;
        r_out_cost <= n_out_cost;
        r_out_unr  <= n_out_unr;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'({r_out_cost, r_out_to, r_out_from});
    assign m_axis_tuser  = r_out_unr;
    assign m_axis_tlast  = r_out_last;

    // root stays in the tree for the whole search
    a_root_in_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> r_in_tree[0])
        else $error("root vertex missing from tree during scan");

    // a chosen vertex is never already in the tree
    a_new_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_found) |-> !r_in_tree[r_by])
        else $error("chosen vertex already in tree");

    // each reachable edge adds exactly one vertex
    a_tree_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_found) |=>
            ($countones(r_in_tree) == $past($countones(r_in_tree)) + 1))
        else $error("tree did not grow by one vertex");

    // search holds off input
    a_no_load_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid || (r_state == ST_EMIT)) |-> !s_axis_tready)
        else $error("input accepted during search");

endmodule

/* tb/sv/prim_minimum_spanning_tree_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core_test
// Self-checking bench: streams adjacency matrices into the core, predicts the
// Prim tree edges in step and checks every edge word field by field. A short
// table of directed loads comes first, then randomised phases of vertex
// counts, matrix fills and exact, short or long loads, with bursty input and a
// stalling output side.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_core_test;

    localparam int     CFG_W        = pmst_pkg::CFG_W;
    localparam int     VTX_FIELD_W  = pmst_pkg::VTX_FIELD_W;
    localparam int     VC_MIN       = pmst_pkg::VC_MIN;
    localparam logic [CFG_W-1:0] CFG_VC_RESET = pmst_pkg::CFG_VC_RESET;

    localparam int     CLK_PERIOD   = 8;
    localparam int     MAX_V        = 16;
    localparam int     W_BITS       = 16;
    localparam int     STORE_DEPTH  = MAX_V * MAX_V;
    localparam int     IN_TW        = ((W_BITS + 7) / 8) * 8;
    localparam int     OUT_TW       = ((2 * VTX_FIELD_W + W_BITS + 7) / 8) * 8;
    localparam int     DIR_N        = 25;
    localparam int     RANDOM_WORDS = 500;
    localparam int     DRAIN_CYCLES = STORE_DEPTH + 40;
    localparam longint LIMIT_NS     = 4_000_000;

    typedef enum logic [1:0] {FILL_DENSE, FILL_TIES, FILL_SPARSE} t_fill;
    typedef enum logic [1:0] {LOAD_EXACT, LOAD_SHORT, LOAD_LONG} t_load_kind;

    typedef struct packed {
        logic [VTX_FIELD_W-1:0] src;
        logic [VTX_FIELD_W-1:0] dst;
        logic [W_BITS-1:0]      cost;
        logic                   unreach;
        logic                   final_edge;
    } t_tree_edge;

    typedef struct packed {
        logic [CFG_W-1:0]  vc;
        logic [W_BITS-1:0] weight;
        logic              last;
        logic              typed;
        t_tree_edge        edge_exp;
    } t_dir_row;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_TW-1:0]    s_axis_tdata  = '0;  // edge_weight
    logic                s_axis_tlast  = 1'b0;  // last_entry
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_TW-1:0]   m_axis_tdata;  // edge_from, edge_to, edge_cost
    logic                m_axis_tuser;  // unreachable
    logic                m_axis_tlast;  // last_edge

    // shadow of the core
    logic [W_BITS-1:0]   weight_mem [STORE_DEPTH];
    bit                  mem_written [STORE_DEPTH];
    logic [7:0]          wr_addr     = '0;
    logic [CFG_W-1:0]    vc_shadow   = CFG_VC_RESET;

    t_tree_edge          edge_q [$];
    t_tree_edge          tree_buf [$];

    int                  err_count    = 0;
    int                  words_sent   = 0;
    int                  loads_done   = 0;
    int                  edges_seen   = 0;
    int                  unreach_seen = 0;
    int                  burst_left   = 0;
    int                  rx_mode      = 0;
    int                  rx_left      = 0;
    int                  rx_tick      = 0;

    prim_minimum_spanning_tree_core #(
        .MAX_VERTICES (MAX_V),
        .WEIGHT_BITS  (W_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int clamp_vertices(logic [CFG_W-1:0] v);
        if (v < VC_MIN) return VC_MIN;
        if (v > MAX_V) return MAX_V;
        return int'(v);
    endfunction

    function automatic bit store_ready(int n);
        for (int k = 0; k < n * n; k++) begin
            if (!mem_written[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void grow_tree();
        int                n;
        bit                joined [MAX_V];
        bit                found;
        logic [W_BITS-1:0] best;
        logic [W_BITS-1:0] w;
        int                bi;
        int                bj;
        t_tree_edge        t;
        n = clamp_vertices(vc_shadow);
        tree_buf.delete();
        foreach (joined[k]) joined[k] = 1'b0;
        joined[0] = 1'b1;
        for (int e = 0; e < n - 1; e++) begin
            found = 1'b0;
            best  = '0;
            bi    = 0;
            bj    = 0;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    if (joined[i] && !joined[j]) begin
                        w = weight_mem[i * n + j];
                        if (w != 0 && (!found || w < best)) begin
                            found = 1'b1;
                            best  = w;
                            bi    = i;
                            bj    = j;
                        end
                    end
                end
            end
            if (found) joined[bj] = 1'b1;
            // no candidate: bi, bj and best stay zero
            t = '{src: bi[VTX_FIELD_W-1:0], dst: bj[VTX_FIELD_W-1:0], cost: best,
                  unreach: !found, final_edge: (e == n - 2)};
            tree_buf.push_back(t);
        end
    endfunction

    //      vc     weight    last  typed  expected edge (src dst cost unr last)
    function automatic t_dir_row dir_row(int k);
        t_dir_row r;
        case (k)
            0:  r = '{5'd2, 16'h0000, 1'b0, 1'b0, '0};
            1:  r = '{5'd2, 16'hFFFF, 1'b0, 1'b0, '0};
            2:  r = '{5'd2, 16'hFFFF, 1'b0, 1'b0, '0};
            3:  r = '{5'd2, 16'h0000, 1'b1, 1'b1, '{4'd0, 4'd1, 16'hFFFF, 1'b0, 1'b1}};
            4:  r = '{5'd2, 16'h0000, 1'b0, 1'b0, '0};
            5:  r = '{5'd2, 16'h0000, 1'b0, 1'b0, '0};
            6:  r = '{5'd2, 16'h0000, 1'b0, 1'b0, '0};
            7:  r = '{5'd2, 16'h0000, 1'b1, 1'b1, '{4'd0, 4'd0, 16'h0000, 1'b1, 1'b1}};
            8:  r = '{5'd2, 16'h0007, 1'b0, 1'b0, '0};
            9:  r = '{5'd2, 16'h0001, 1'b0, 1'b0, '0};
            10: r = '{5'd2, 16'h0001, 1'b0, 1'b0, '0};
            11: r = '{5'd2, 16'h0007, 1'b1, 1'b1, '{4'd0, 4'd1, 16'h0001, 1'b0, 1'b1}};
            // three vertices with tied weights
            12: r = '{5'd3, 16'h0000, 1'b0, 1'b0, '0};
            13: r = '{5'd3, 16'h0005, 1'b0, 1'b0, '0};
            14: r = '{5'd3, 16'h0005, 1'b0, 1'b0, '0};
            15: r = '{5'd3, 16'h0005, 1'b0, 1'b0, '0};
            16: r = '{5'd3, 16'h0000, 1'b0, 1'b0, '0};
            17: r = '{5'd3, 16'h0003, 1'b0, 1'b0, '0};
            18: r = '{5'd3, 16'h0005, 1'b0, 1'b0, '0};
            19: r = '{5'd3, 16'h0003, 1'b0, 1'b0, '0};
            20: r = '{5'd3, 16'h0000, 1'b1, 1'b0, '0};
            // early tlast: tail of the matrix is stale
            21: r = '{5'd3, 16'h0000, 1'b0, 1'b0, '0};
            22: r = '{5'd3, 16'h0009, 1'b0, 1'b0, '0};
            23: r = '{5'd3, 16'h0000, 1'b0, 1'b0, '0};
            24: r = '{5'd3, 16'h0002, 1'b1, 1'b0, '0};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [W_BITS-1:0] pick_weight(t_fill fill);
        int r;
        case (fill)
            FILL_DENSE: begin
                r = $urandom_range(0, 19);
                if (r == 0) return '0;
                if (r == 1) return '1;
                return W_BITS'($urandom_range(1, (1 << W_BITS) - 1));
            end
            FILL_TIES: return W_BITS'($urandom_range(0, 3));
            default: begin
                if ($urandom_range(0, 3) == 0) return W_BITS'($urandom_range(1, (1 << W_BITS) - 1));
                return '0;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns  mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d (edge word %0d)",
                                      name, got, want, edges_seen));
    endtask

    task automatic push_word(logic [W_BITS-1:0] w, logic last, logic typed,
                             t_tree_edge typed_edge);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TW'(w);
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        weight_mem[wr_addr]  = w;
        mem_written[wr_addr] = 1'b1;
        wr_addr++;
        words_sent++;
        if (last) begin
            wr_addr = '0;
            loads_done++;
            grow_tree();
            if (typed) edge_q.push_back(typed_edge);
            else foreach (tree_buf[k]) edge_q.push_back(tree_buf[k]);
        end
    endtask

    task automatic sender_gap();
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // hold the input off until every pending edge word is out
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (edge_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_vertex_count(logic [CFG_W-1:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        vc_shadow    = v;
    endtask

    task automatic send_matrix(int n, t_load_kind kind, t_fill fill);
        int len;
        case (kind)
            LOAD_SHORT: len = $urandom_range(1, n * n - 1);
            LOAD_LONG:  len = n * n + $urandom_range(1, 12);
            default:    len = n * n;
        endcase
        for (int k = 0; k < len; k++) begin
            sender_gap();
            push_word(pick_weight(fill), k == len - 1, 1'b0, '0);
        end
    endtask

    // output side stalls in modes of its own
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((rx_tick % 32) >= 20);
        endcase
    end

    always @(posedge i_clk) begin : edge_monitor
        t_tree_edge got;
        t_tree_edge want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{src:        m_axis_tdata[VTX_FIELD_W-1:0],
                    dst:        m_axis_tdata[2*VTX_FIELD_W-1:VTX_FIELD_W],
                    cost:       m_axis_tdata[2*VTX_FIELD_W+W_BITS-1:2*VTX_FIELD_W],
                    unreach:    m_axis_tuser,
                    final_edge: m_axis_tlast};
            edges_seen++;
            if (got.unreach) unreach_seen++;
            if (edge_q.size() == 0) begin
                report_mismatch($sformatf("edge word %0d with none expected", edges_seen));
            end else begin
                want = edge_q.pop_front();
                check_field("edge_from",   got.src,        want.src);
                check_field("edge_to",     got.dst,        want.dst);
                check_field("edge_cost",   got.cost,       want.cost);
                check_field("unreachable", got.unreach,    want.unreach);
                check_field("last_edge",   got.final_edge, want.final_edge);
            end
        end
    end

    initial begin
        t_dir_row         row;
        int               r;
        int               n;
        int               loads;
        logic [CFG_W-1:0] v;
        t_load_kind       kind;
        t_fill            fill;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            row = dir_row(k);
            if (row.vc != vc_shadow) write_vertex_count(row.vc);
            sender_gap();
            push_word(row.weight, row.last, row.typed, row.edge_exp);
        end

        // full-size load first so that every store entry holds a value
        write_vertex_count(5'd16);
        send_matrix(MAX_V, LOAD_EXACT, FILL_DENSE);

        while (words_sent < DIR_N + RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 2)       v = 5'd31;
            else if (r < 4)  v = CFG_W'($urandom_range(17, 30));
            else if (r < 8)  v = 5'd0;
            else if (r < 12) v = 5'd1;
            else if (r < 16) v = 5'd16;
            else             v = CFG_W'($urandom_range(2, 8));
            write_vertex_count(v);
            n     = clamp_vertices(v);
            loads = (n == MAX_V) ? 1 : $urandom_range(1, 4);
            repeat (loads) begin
                r = $urandom_range(0, 99);
                if (r < 70)      kind = LOAD_EXACT;
                else if (r < 85) kind = LOAD_SHORT;
                else             kind = LOAD_LONG;
                if (kind == LOAD_SHORT && !store_ready(n)) kind = LOAD_EXACT;
                fill = t_fill'($urandom_range(0, 2));
                send_matrix(n, kind, fill);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d matrix loads over %0d weight words at vertex counts 2..16,",
                 loads_done, words_sent);
        $display("and checked %0d tree edge words, %0d of them unreachable.",
                 edges_seen, unreach_seen);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d edge words outstanding.", edge_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
